[src/lfu_pkg.sv]
//------------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
//------------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 31;
  localparam int unsigned RdW  = 32;
  localparam int unsigned CapW = 5;

  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  localparam logic [RdW-1:0] MinusOne = '1;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [RdW-1:0]  read_value;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
  } rsp_t;

endpackage

[src/lfu_if.sv]
//------------------------------------------------------------------------------
// lfu_if
// Valid/ready channel carrying one request or response word.
//------------------------------------------------------------------------------
interface lfu_req_if;
  logic          valid;
  logic          ready;
  lfu_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
  logic          valid;
  logic          ready;
  lfu_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/lfu_cache_table_top.sv]
//------------------------------------------------------------------------------
// lfu_cache_table_top
// Fully associative key-value store with LFU replacement, LRU tiebreak.
//------------------------------------------------------------------------------
// One request word is in flight at a time. Its response word turns valid
// after the scan pass, the decision step, the update pass and the insert
// step. The response holds until it is taken, and the next request is
// accepted only after that, so a stall on the response delays it. Entries sit
// in a simple dual-port synchronous memory: a scan pass reads every entry
// once to find the key match and the victim, then an update pass reads each
// valid entry, adjusts recency, count and value, and writes it back when a
// touch or insert needs it, skipping the victim. Valid bits and occupancy
// are flops cleared at reset; no clearing pass is needed.
module lfu_cache_table_top #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0]  cfg_wdata_i,
  lfu_req_if.sink                   req_i,
  lfu_rsp_if.source                 rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RecW = IdxW;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned EntW = lfu_pkg::KeyW + lfu_pkg::ValW + COUNT_BITS + RecW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef struct packed {
    logic [lfu_pkg::KeyW-1:0] key;
    logic [lfu_pkg::ValW-1:0] value;
    logic [COUNT_BITS-1:0]    count;
    logic [RecW-1:0]          rec;
  } ent_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StScan = 6'b000010,
    StDec  = 6'b000100,
    StUpd  = 6'b001000,
    StDone = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  // entry memory
  ent_t             mem_q [ENTRIES];
  ent_t             rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  ent_t             mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  // control state
  state_e                 state_q, state_d;
  logic [ENTRIES-1:0]     valid_q;
  logic [OccW-1:0]        occ_q;
  logic [lfu_pkg::CapW-1:0] cap_q;
  logic [OccW:0]          ptr_q;   // read pointer, one ahead of data
  lfu_pkg::req_t          req_q;
  logic                   hit_q;
  logic [IdxW-1:0]        hidx_q;
  ent_t                   hent_q;
  logic                   vfound_q;
  logic [IdxW-1:0]        vidx_q;
  ent_t                   vent_q;
  lfu_pkg::rsp_t          rsp_q;
  // per-op plan, set at end of scan
  logic                   doins_q, doev_q, touch_q;
  logic [IdxW-1:0]        tgt_q;
  logic [RecW-1:0]        tref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= lfu_pkg::CapW'(16);
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  // scan data index: memory data lags the pointer by one
  logic [IdxW-1:0] didx;
  logic            dvalid;
  assign didx   = IdxW'(ptr_q - 1'b1);
  assign dvalid = (ptr_q != '0) && valid_q[didx];

  logic [OccW-1:0] cap_eff;
  assign cap_eff = (cap_q > ENTRIES) ? OccW'(ENTRIES) : OccW'(cap_q);

  // first free slot, priority search over valid bits
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) if (!valid_q[i]) free_idx = IdxW'(i);
  end

  // plan computed from scan result
  logic pl_ins, pl_ev, pl_touch;
  always_comb begin
    pl_touch = hit_q && (req_q.func == lfu_pkg::FuncGet || cap_eff != '0);
    pl_ins   = !hit_q && req_q.func == lfu_pkg::FuncPut && cap_eff != '0;
    pl_ev    = pl_ins && occ_q >= cap_eff && vfound_q;
  end

  // entry update during update pass
  ent_t upd;
  logic upd_we;
  always_comb begin
    upd    = rdata_q;
    upd_we = 1'b0;
    if (dvalid) begin
      upd_we = 1'b1;
      if (touch_q) begin
        if (didx == tgt_q) begin
          upd.rec = '0;
          if (rdata_q.count != CountMax) upd.count = rdata_q.count + 1'b1;
          if (req_q.func == lfu_pkg::FuncPut) upd.value = req_q.value;
        end else if (rdata_q.rec < tref_q) upd.rec = rdata_q.rec + 1'b1;
      end else if (doins_q) begin
        if (doev_q && didx == tgt_q) upd_we = 1'b0;
        else begin
          if (doev_q && rdata_q.rec > tref_q) upd.rec = rdata_q.rec - 1'b1;
          upd.rec = upd.rec + 1'b1;
        end
      end else upd_we = 1'b0;
    end
  end

  logic last_ptr;
  assign last_ptr = (ptr_q == (OccW+1)'(ENTRIES));

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = didx;
    mem_wdata = upd;
    mem_raddr = IdxW'(ptr_q);
    case (state_q)
      StIdle:  if (req_i.valid) state_d = StScan;
      StScan:  if (last_ptr) state_d = StDec;
      StDec:   state_d = StUpd;
      StUpd: begin
        mem_we = upd_we && ptr_q != '0;
        if (last_ptr) state_d = StDone;
      end
      StDone: begin
        mem_we    = doins_q;
        mem_waddr = tgt_q;
        mem_wdata = '{key: req_q.key, value: req_q.value,
                      count: COUNT_BITS'(1), rec: '0};
        state_d   = StOut;
      end
      StOut:   if (rsp_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = (state_q == StOut);
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      occ_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: if (req_i.valid) ptr_q <= (OccW+1)'(1);
        StScan: ptr_q <= last_ptr ? '0 : ptr_q + 1'b1;
        StDec:  ptr_q <= (OccW+1)'(1);
        StUpd: begin
          ptr_q <= last_ptr ? '0 : ptr_q + 1'b1;
          if (last_ptr && doev_q) begin
            valid_q[tgt_q] <= 1'b0;
            occ_q <= occ_q - 1'b1;
          end
        end
        // victim was already counted out at the end of the update pass
        StDone: if (doins_q) begin
          valid_q[tgt_q] <= 1'b1;
          occ_q <= occ_q + OccW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        req_q    <= req_i.data;
        hit_q    <= 1'b0;
        vfound_q <= 1'b0;
      end
      StScan: if (dvalid) begin
        if (rdata_q.key == req_q.key) begin
          hit_q  <= 1'b1;
          hidx_q <= didx;
          hent_q <= rdata_q;
        end
        if (!vfound_q || rdata_q.count < vent_q.count ||
            (rdata_q.count == vent_q.count && rdata_q.rec > vent_q.rec)) begin
          vfound_q <= 1'b1;
          vidx_q   <= didx;
          vent_q   <= rdata_q;
        end
      end
      StDec: begin
        touch_q <= pl_touch;
        doins_q <= pl_ins && (pl_ev || occ_q < OccW'(ENTRIES));
        doev_q  <= pl_ev;
        tgt_q   <= pl_touch ? hidx_q : (pl_ev ? vidx_q : free_idx);
        tref_q  <= pl_touch ? hent_q.rec : vent_q.rec;
        rsp_q.hit         <= hit_q;
        rsp_q.read_value  <= (hit_q && req_q.func == lfu_pkg::FuncGet) ?
                             {1'b0, hent_q.value} : lfu_pkg::MinusOne;
        rsp_q.evicted     <= pl_ev;
        rsp_q.evicted_key <= pl_ev ? vent_q.key : '0;
      end
      default: ;
    endcase
  end

endmodule

[tb/sv/testbench.sv]
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the LFU cache table: drives get/put words with
// random gaps, predicts each response with a behavioral LFU/LRU store and
// compares every response word field by field.
//------------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned CountMax   = 65535;
  localparam int unsigned CycleLimit = 400000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [lfu_pkg::CapW-1:0] cfg_wdata_i;

  lfu_req_if req_if ();
  lfu_rsp_if rsp_if ();

  lfu_cache_table_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  // Shadow copy of the store
  logic                     shd_valid [NumEntries];
  logic [lfu_pkg::KeyW-1:0] shd_key   [NumEntries];
  logic [lfu_pkg::ValW-1:0] shd_value [NumEntries];
  int unsigned              shd_count [NumEntries];
  int unsigned              shd_rank  [NumEntries];
  int unsigned              shd_occ;
  logic [lfu_pkg::CapW-1:0] shd_cap;

  lfu_pkg::rsp_t            expected_rsps [$];
  int unsigned              error_cnt;
  int unsigned              cycle_cnt;
  int unsigned              rsp_cnt;
  logic [lfu_pkg::KeyW-1:0] recent_keys [$];

  // Clock and cycle watchdog
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    error_cnt++;
  endtask

  // Make entry most recently used and raise its count
  function automatic void touch_entry(input int idx);
    for (int i = 0; i < NumEntries; i++)
      if (shd_valid[i] && i != idx && shd_rank[i] < shd_rank[idx]) shd_rank[i]++;
    shd_rank[idx] = 0;
    if (shd_count[idx] < CountMax) shd_count[idx]++;
  endfunction

  function automatic lfu_pkg::rsp_t predict_access(input lfu_pkg::req_t req);
    lfu_pkg::rsp_t rsp;
    int            idx;
    int            vic;
    int            slot;
    int unsigned   cap;
    idx  = -1;
    vic  = -1;
    slot = -1;
    cap  = (shd_cap > NumEntries) ? NumEntries : shd_cap;
    rsp  = '{hit: 1'b0, read_value: lfu_pkg::MinusOne, evicted: 1'b0, evicted_key: '0};
    for (int i = NumEntries - 1; i >= 0; i--)
      if (shd_valid[i] && shd_key[i] == req.key) idx = i;
    rsp.hit = (idx >= 0);
    if (req.func == lfu_pkg::FuncGet) begin
      if (idx >= 0) begin
        touch_entry(idx);
        rsp.read_value = {1'b0, shd_value[idx]};
      end
    end else if (cap != 0) begin
      if (idx >= 0) begin
        shd_value[idx] = req.value;
        touch_entry(idx);
      end else begin
        if (shd_occ >= cap) begin
          for (int i = 0; i < NumEntries; i++)
            if (shd_valid[i] && (vic < 0 || shd_count[i] < shd_count[vic] ||
                (shd_count[i] == shd_count[vic] && shd_rank[i] > shd_rank[vic])))
              vic = i;
          if (vic >= 0) begin
            rsp.evicted     = 1'b1;
            rsp.evicted_key = shd_key[vic];
            shd_valid[vic]  = 1'b0;
            shd_occ--;
            for (int i = 0; i < NumEntries; i++)
              if (shd_valid[i] && shd_rank[i] > shd_rank[vic]) shd_rank[i]--;
            slot = vic;
          end
        end
        if (slot < 0)
          for (int i = NumEntries - 1; i >= 0; i--)
            if (!shd_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < NumEntries; i++)
            if (shd_valid[i]) shd_rank[i]++;
          shd_valid[slot] = 1'b1;
          shd_key[slot]   = req.key;
          shd_value[slot] = req.value;
          shd_count[slot] = 1;
          shd_rank[slot]  = 0;
          shd_occ++;
        end
      end
    end
    return rsp;
  endfunction

  // Send one request word after a random gap; valid stays up into the
  // next call when that one has no gap
  task automatic send_word(input logic func, input logic [lfu_pkg::KeyW-1:0] key,
                           input logic [lfu_pkg::ValW-1:0] value);
    lfu_pkg::req_t req;
    int            gap;
    req = '{func: func, key: key, value: value};
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsps.push_back(predict_access(req));
    recent_keys.push_back(key);
    if (recent_keys.size() > 24) void'(recent_keys.pop_front());
  endtask

  // Response sink with random stalls
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      rsp_cnt++;
      if (expected_rsps.size() == 0) begin
        report("unexpected word", 64'(rsp_if.data.read_value), 64'd0);
      end else begin
        lfu_pkg::rsp_t exp_rsp;
        exp_rsp = expected_rsps.pop_front();
        if (rsp_if.data.hit !== exp_rsp.hit)
          report("hit", 64'(rsp_if.data.hit), 64'(exp_rsp.hit));
        if (rsp_if.data.read_value !== exp_rsp.read_value)
          report("read_value", 64'(rsp_if.data.read_value), 64'(exp_rsp.read_value));
        if (rsp_if.data.evicted !== exp_rsp.evicted)
          report("evicted", 64'(rsp_if.data.evicted), 64'(exp_rsp.evicted));
        if (rsp_if.data.evicted_key !== exp_rsp.evicted_key)
          report("evicted_key", 64'(rsp_if.data.evicted_key), 64'(exp_rsp.evicted_key));
      end
    end
  end

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::CapW-1:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shd_cap = cap;
  endtask

  // Key pick: mostly a small pool so hits and evictions are common
  function automatic logic [lfu_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1, 2:    return (recent_keys.size() != 0) ?
                 recent_keys[$urandom_range(0, recent_keys.size() - 1)] : 32'd0;
      default: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 23'd0, 5'($urandom_range(0, 23))};
    endcase
  endfunction

  task automatic test_directed();
    send_word(lfu_pkg::FuncGet, 32'h0, 31'h0);                 // miss on empty store
    send_word(lfu_pkg::FuncPut, 32'h0, 31'h0);
    send_word(lfu_pkg::FuncPut, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_word(lfu_pkg::FuncGet, 32'hFFFF_FFFF, 31'h0);
    send_word(lfu_pkg::FuncGet, 32'h0, 31'h7FFF_FFFF);
    send_word(lfu_pkg::FuncPut, 32'h0, 31'h5555_5555);         // update present key
    send_word(lfu_pkg::FuncGet, 32'h0, 31'h0);
    for (int i = 1; i <= 16; i++)                              // fill and evict
      send_word(lfu_pkg::FuncPut, 32'hA5A5_0000 + i, 31'(31'h2AAA_AAAA ^ i));
  endtask

  task automatic test_capacity_zero();
    set_capacity(5'd0);
    send_word(lfu_pkg::FuncPut, 32'h1234_5678, 31'h1);         // ignored
    send_word(lfu_pkg::FuncPut, 32'hA5A5_0010, 31'h2);         // present, still ignored
    send_word(lfu_pkg::FuncGet, 32'hA5A5_0010, 31'h0);
    send_word(lfu_pkg::FuncGet, 32'h1234_5678, 31'h0);
  endtask

  task automatic test_lowered_capacity();
    set_capacity(5'd2);                                        // below occupancy
    for (int i = 0; i < 4; i++)
      send_word(lfu_pkg::FuncPut, 32'hC0DE_0000 + i, 31'(i));
    set_capacity(5'd31);                                       // above entry count
    for (int i = 0; i < 4; i++)
      send_word(lfu_pkg::FuncPut, 32'hBEEF_0000 + i, 31'(i));
  endtask

  // Repeated hits on one entry, then a put that evicts a less often used entry
  task automatic test_saturation();
    set_capacity(5'd1);
    send_word(lfu_pkg::FuncPut, 32'h5A5A_5A5A, 31'h1);
    for (int i = 0; i < 40; i++) send_word(lfu_pkg::FuncGet, 32'h5A5A_5A5A, 31'h0);
    send_word(lfu_pkg::FuncPut, 32'h6B6B_6B6B, 31'h2);
  endtask

  task automatic test_random();
    logic [lfu_pkg::CapW-1:0] caps [6] = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd16};
    foreach (caps[c]) begin
      set_capacity(caps[c]);
      for (int n = 0; n < 120; n++)
        send_word(logic'($urandom_range(0, 1)), pick_key(), 31'($urandom));
    end
  endtask

  initial begin
    error_cnt    = 0;
    cycle_cnt    = 0;
    rsp_cnt      = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    shd_cap      = 5'd16;
    shd_occ      = 0;
    for (int i = 0; i < NumEntries; i++) begin
      shd_valid[i] = 1'b0;
      shd_key[i]   = '0;
      shd_value[i] = '0;
      shd_count[i] = 0;
      shd_rank[i]  = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_zero();
    test_lowered_capacity();
    test_saturation();
    test_random();
    drain();
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lfu_pkg.sv
src/lfu_if.sv
src/lfu_cache_table_top.sv
tb/sv/testbench.sv
